// ===== src/assert_macros.svh =====
// Assertion macros for the RTL; skbs_search_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/skbs_pkg.sv =====
// Types and constants of the sorted-key binary search core.
package skbs_pkg;

  localparam int unsigned SLOT_W = 10;
  localparam int unsigned KEY_W  = 40;
  localparam int unsigned CNT_W  = 11;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } skbs_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] position;
  } skbs_rsp_t;

endpackage

// ===== src/skbs_key_ram.sv =====
// Key table: one write port, one read port, registered read data.
module skbs_key_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/skbs_search_ctrl.sv =====
// Request handling, count register and binary search sequencer.
`include "assert_macros.svh"
module skbs_search_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 40,
  parameter int unsigned AW          = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  skbs_pkg::skbs_req_t             req_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [skbs_pkg::CNT_W-1:0]      cfg_data_i,
  output logic                            rsp_strobe_o,
  output skbs_pkg::skbs_rsp_t             rsp_o,
  output logic                            mem_we_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic [KEY_BITS-1:0]             mem_wdata_o,
  output logic                            mem_re_o,
  output logic [AW-1:0]                   mem_raddr_o,
  input  logic [KEY_BITS-1:0]             mem_rdata_i
);
  import skbs_pkg::*;

  localparam int unsigned LAST = TABLE_DEPTH - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_HI   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid_c;
  logic [KEY_BITS-1:0] want_q, want_d;
  logic [CNT_W-1:0]    count_q;
  logic                strobe_q, strobe_d;
  skbs_rsp_t           rsp_q, rsp_d;
  logic [31:0]         count32;
  logic [AW-1:0]       hi_init;
  logic                slot_ok;

  assign count32     = 32'(count_q);
  assign hi_init     = (count32 > TABLE_DEPTH) ? AW'(LAST) : AW'(count32 - 32'd1);
  assign slot_ok     = 32'(req_i.slot) < TABLE_DEPTH;
  assign mid_c       = lo_q + ((hi_q - lo_q) >> 1);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;
  assign mem_waddr_o = AW'(req_i.slot);
  assign mem_wdata_o = KEY_BITS'(req_i.key);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    want_d      = want_q;
    strobe_d    = 1'b0;
    rsp_d       = rsp_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = mid_c;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (req_i.op == OP_LOAD) begin
            mem_we_o = slot_ok;
          end else if (count_q == '0) begin
            strobe_d = 1'b1;
            rsp_d    = '0;
          end else begin
            want_d  = KEY_BITS'(req_i.key);
            lo_d    = '0;
            hi_d    = hi_init;
            state_d = S_TEST;
          end
        end
      end
      S_TEST: begin
        mid_d    = mid_c;
        mem_re_o = 1'b1;
        if (hi_q > mid_c && mid_c > lo_q) begin
          mem_raddr_o = mid_c;
          state_d     = S_CMP;
        end else begin
          mem_raddr_o = lo_q;
          state_d     = S_LO;
        end
      end
      S_CMP: begin
        priority if (mem_rdata_i > want_q) begin
          hi_d    = mid_q;
          state_d = S_TEST;
        end else if (mem_rdata_i < want_q) begin
          lo_d    = mid_q;
          state_d = S_TEST;
        end else begin
          strobe_d       = 1'b1;
          rsp_d.found    = 1'b1;
          rsp_d.position = SLOT_W'(mid_q);
          state_d        = S_IDLE;
        end
      end
      S_LO: begin
        if (mem_rdata_i == want_q) begin
          strobe_d       = 1'b1;
          rsp_d.found    = 1'b1;
          rsp_d.position = SLOT_W'(lo_q);
          state_d        = S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = hi_q;
          state_d     = S_HI;
        end
      end
      S_HI: begin
        strobe_d = 1'b1;
        if (mem_rdata_i == want_q) begin
          rsp_d.found    = 1'b1;
          rsp_d.position = SLOT_W'(hi_q);
        end else begin
          rsp_d = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    want_q <= want_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_strobe_o = strobe_q;
  assign rsp_o        = rsp_q;

  `ASSERT_CLK(a_strobe_idle, strobe_q |-> (state_q == S_IDLE), "result while searching")
  `ASSERT_CLK(a_miss_zero, (strobe_q && !rsp_q.found) |-> (rsp_q.position == '0),
              "miss with nonzero position")
  `ASSERT_CLK(a_bounds, (state_q == S_TEST) |-> (lo_q <= hi_q), "bounds crossed")
  `ASSERT_NEVER(a_write_busy, mem_we_o && busy_o, "table write during search")
  `ASSERT_CLK(a_probe_inside, (state_q == S_CMP) |-> (lo_q < mid_q && mid_q < hi_q),
              "probe outside bounds")

endmodule

// ===== src/sorted_key_binary_search_core.sv =====
// Top level of the sorted-key binary search core.
//
//  channel   direction  handshake                    payload
//  request   in         start / busy                 req_i (op, slot, key)
//  result    out        rsp_strobe_o, one cycle      rsp_o (found, position)
//  config    in         cfg_valid_i / cfg_ready_o    cfg_data_i (entry_count)
//
// A load or a lookup with entry_count 0 is done from idle and busy stays low. Any other
// lookup holds busy for each halving step (probe read, compare) and then for the end
// checks of lo and hi; a hit while halving ends it early.
// The result strobe is high in the cycle after the last compare, when busy is low again.
// Reset clears the count and control state; the key table is not cleared.
// The receiver cannot stall; the config port is ready whenever busy is low.
module sorted_key_binary_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  skbs_pkg::skbs_req_t        req_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [skbs_pkg::CNT_W-1:0] cfg_data_i,
  output logic                       rsp_strobe_o,
  output skbs_pkg::skbs_rsp_t        rsp_o
);
  import skbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [KEY_BITS-1:0] mem_wdata, mem_rdata;

  skbs_search_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .rsp_strobe_o(rsp_strobe_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  skbs_key_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KEY_BITS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ===== tb/sorted_key_binary_search_core_tb.sv =====
// Testbench for the sorted-key binary search core: directed and random loads and lookups.
`timescale 1ns / 1ps

module sorted_key_binary_search_core_tb;
  import skbs_pkg::*;

  localparam int unsigned DEPTH          = 1024;
  localparam int unsigned LOOKUP_LATENCY = 32;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  skbs_req_t       req;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  logic            rsp_strobe;
  skbs_rsp_t       rsp;

  // shadow of the block: key table and count register
  logic [KEY_W-1:0] key_table_m [DEPTH];
  logic [CNT_W-1:0] entry_count_m;

  skbs_rsp_t   pending_results[$];
  skbs_rsp_t   want_rsp;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned load_cnt;
  int unsigned lookup_cnt;
  int unsigned hit_cnt;
  int unsigned cfg_cnt;
  int unsigned gap_max;

  sorted_key_binary_search_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .rsp_strobe_o(rsp_strobe),
    .rsp_o       (rsp)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  function automatic int unsigned active_entries();
    if (entry_count_m > DEPTH) return DEPTH;
    return 32'(entry_count_m);
  endfunction

  // binary search as the block runs it: narrow while lo < mid < hi, then check lo, then hi
  function automatic logic search_sorted_table(input logic [KEY_W-1:0] want,
                                               output logic [SLOT_W-1:0] where);
    int unsigned n, lo, hi, mid;
    where = '0;
    n = active_entries();
    if (n == 0) return 1'b0;
    hi  = n - 1;
    lo  = 0;
    mid = hi / 2;
    while (hi > mid && mid > lo) begin
      if (key_table_m[mid] > want) begin
        hi = mid;
      end else if (key_table_m[mid] < want) begin
        lo = mid;
      end else begin
        where = mid[SLOT_W-1:0];
        return 1'b1;
      end
      mid = (hi - lo) / 2 + lo;
    end
    if (key_table_m[lo] == want) begin
      where = lo[SLOT_W-1:0];
      return 1'b1;
    end
    if (key_table_m[hi] == want) begin
      where = hi[SLOT_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [KEY_W-1:0] key);
    int unsigned gap;
    skbs_rsp_t   res;
    logic [SLOT_W-1:0] where;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start    = 1'b1;
    req.op   = op;
    req.slot = slot;
    req.key  = key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_LOAD) begin
      key_table_m[slot] = key;
      load_cnt++;
    end else begin
      res.found    = search_sorted_table(key, where);
      res.position = where;
      pending_results.push_back(res);
      lookup_cnt++;
      if (res.found) hit_cnt++;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (LOOKUP_LATENCY) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    entry_count_m = value;
    cfg_cnt++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic send_lookup(input logic [KEY_W-1:0] key);
    send_item(OP_LOOKUP, SLOT_W'($urandom), key);
  endtask

  // mostly keys present in the searched range, some near misses, some random
  task automatic random_lookup();
    int unsigned n, sel, idx;
    logic [KEY_W-1:0] k;
    n   = active_entries();
    sel = $urandom_range(0, 9);
    k   = rand_key();
    if (n > 0 && sel < 8) begin
      idx = $urandom_range(0, n - 1);
      k   = key_table_m[idx];
      if (sel == 6) k = k + KEY_W'(1);
      if (sel == 7) k = k - KEY_W'(1);
    end
    send_lookup(k);
  endtask

  task automatic load_table(input int unsigned n, input bit unsorted);
    logic [63:0] span, acc, inc;
    span = 64'hFF_FFFF_FFFF / 64'(n);
    acc  = '0;
    for (int unsigned i = 0; i < n; i++) begin
      inc = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom} % (span + 1);
      acc = acc + inc;
      send_item(OP_LOAD, i[SLOT_W-1:0], unsorted ? rand_key() : acc[KEY_W-1:0]);
    end
  endtask

  task automatic test_empty_table();
    gap_max = 0;
    send_lookup(rand_key());
    set_entry_count('0);
    send_lookup('0);
  endtask

  task automatic test_edge_entries();
    gap_max = 0;
    send_item(OP_LOAD, 10'd0, 40'h00_0000_0000);
    send_item(OP_LOAD, 10'd1, 40'h00_0000_1000);
    send_item(OP_LOAD, 10'd2, 40'h00_0000_1000);
    send_item(OP_LOAD, 10'd3, 40'hFF_FFFF_FFFF);
    send_item(OP_LOAD, 10'd1023, rand_key());
    set_entry_count(11'd4);
    gap_max = 3;
    send_lookup(40'h00_0000_0000);
    send_lookup(40'h00_0000_1000);
    send_lookup(40'hFF_FFFF_FFFF);
    send_lookup(40'h00_0000_0FFF);
    send_lookup(40'hFF_FFFF_FFFE);
    send_lookup(40'h00_0000_0001);
    set_entry_count(11'd1);
    send_lookup(40'h00_0000_0000);
    send_lookup(40'h00_0000_1000);
    set_entry_count(11'd2);
    send_lookup(40'h00_0000_1000);
    send_lookup(40'hFF_FFFF_FFFF);
    // break the order: largest key in front
    send_item(OP_LOAD, 10'd0, 40'hFF_FFFF_FFFF);
    set_entry_count(11'd4);
    send_lookup(40'hFF_FFFF_FFFF);
    send_lookup(40'h00_0000_0000);
  endtask

  task automatic test_small_tables();
    int unsigned n, cnt;
    for (int unsigned ph = 0; ph < 10; ph++) begin
      gap_max = (ph % 3 == 0) ? 0 : 16;
      n = (ph == 0) ? 2 : $urandom_range(1, 40);
      load_table(n, $urandom_range(0, 4) == 0);
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      set_entry_count(cnt[CNT_W-1:0]);
      for (int unsigned i = 0; i < 12; i++) begin
        if ($urandom_range(0, 9) == 0) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_LOAD, SLOT_W'($urandom_range(0, n - 1)), rand_key());
        end else begin
          random_lookup();
        end
      end
    end
  endtask

  task automatic test_full_table();
    logic [CNT_W-1:0] counts [4];
    counts[0] = 11'd1024;
    counts[1] = 11'd2047;
    counts[2] = CNT_W'($urandom_range(3, 1023));
    counts[3] = CNT_W'($urandom_range(1025, 2046));
    drain_results();
    for (int unsigned i = 0; i < DEPTH; i += 128) begin
      gap_max = $urandom_range(0, 1) * 16;
      if (i == 0) load_table(DEPTH, 1'b0);
    end
    for (int unsigned c = 0; c < 4; c++) begin
      set_entry_count(counts[c]);
      gap_max = (c % 2 == 0) ? 16 : 0;
      for (int unsigned i = 0; i < 20; i++) random_lookup();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result found=%0b position=%0d with none expected",
                                  rsp.found, rsp.position));
      end else begin
        want_rsp = pending_results.pop_front();
        if (rsp.found !== want_rsp.found)
          report_mismatch($sformatf("found %0b, expected %0b", rsp.found, want_rsp.found));
        if (rsp.position !== want_rsp.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    rsp.position, want_rsp.position));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    req           = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    entry_count_m = '0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    load_cnt      = 0;
    lookup_cnt    = 0;
    hit_cnt       = 0;
    cfg_cnt       = 0;
    gap_max       = 0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      key_table_m[i] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_edge_entries();
    test_small_tables();
    test_full_table();

    drain_results();
    repeat (LOOKUP_LATENCY) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Ran %0d loads and %0d lookups (%0d hits) over %0d entry_count writes,",
             load_cnt, lookup_cnt, hit_cnt, cfg_cnt);
    $display("from an empty table up to a full, saturated 1024-entry table.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sorted_key_binary_search_core.f =====
+incdir+src
src/skbs_pkg.sv
src/skbs_key_ram.sv
src/skbs_search_ctrl.sv
src/sorted_key_binary_search_core.sv
tb/sorted_key_binary_search_core_tb.sv
